// ===== rtl/ppi_pkg.sv =====
`default_nettype none
package ppi_pkg;

    // Field widths
    localparam int IDX_W = 12;
    localparam int ANG_W = 15;
    localparam int CD_W  = 24;
    localparam int QA_W  = 16;
    localparam int CNT_W = 7;
    localparam int POS_W = 17;
    localparam int DVD_W = 40;
    localparam int DVS_W = 17;
    localparam int PRD_W = CD_W + ANG_W;

    // Default table sizes
    localparam int DEF_MAX_VERTICAL   = 64;
    localparam int DEF_MAX_HORIZONTAL = 64;
    localparam int DEF_CANDELA_DEPTH  = 4096;

    // Request kinds
    localparam logic [1:0] REQ_LDV   = 2'd0;
    localparam logic [1:0] REQ_LDH   = 2'd1;
    localparam logic [1:0] REQ_LDC   = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // Configuration register indexes
    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_HCOUNT = 1'b1;

    // Outcome of the vertical search
    localparam logic [1:0] VM_ZERO  = 2'd0;
    localparam logic [1:0] VM_EXACT = 2'd1;
    localparam logic [1:0] VM_BLEND = 2'd2;

    typedef logic [5:0] t_op;

    localparam t_op OP_NONE      = 6'd0;
    localparam t_op OP_CAPTURE   = 6'd1;
    localparam t_op OP_LOAD      = 6'd2;
    localparam t_op OP_VLAST_RD  = 6'd3;
    localparam t_op OP_VLAST_CHK = 6'd4;
    localparam t_op OP_V0_RD     = 6'd5;
    localparam t_op OP_V0_LAT    = 6'd6;
    localparam t_op OP_VS_RD     = 6'd7;
    localparam t_op OP_VS_STEP   = 6'd8;
    localparam t_op OP_VS_FAIL   = 6'd9;
    localparam t_op OP_H_LAST_RD = 6'd10;
    localparam t_op OP_H_TOP     = 6'd11;
    localparam t_op OP_MOD_FIX   = 6'd12;
    localparam t_op OP_H0_RD     = 6'd13;
    localparam t_op OP_H0_LAT    = 6'd14;
    localparam t_op OP_HS_RD     = 6'd15;
    localparam t_op OP_HS_STEP   = 6'd16;
    localparam t_op OP_COL_A     = 6'd17;
    localparam t_op OP_COL_B     = 6'd18;
    localparam t_op OP_GP_RD     = 6'd19;
    localparam t_op OP_GP_LAT    = 6'd20;
    localparam t_op OP_GC_RD     = 6'd21;
    localparam t_op OP_GC_LAT    = 6'd22;
    localparam t_op OP_GC_VAL    = 6'd23;
    localparam t_op OP_VAL_ZERO  = 6'd24;
    localparam t_op OP_BSET_V    = 6'd25;
    localparam t_op OP_BSET_H    = 6'd26;
    localparam t_op OP_BMUL      = 6'd27;
    localparam t_op OP_BADD      = 6'd28;
    localparam t_op OP_BDONE     = 6'd29;
    localparam t_op OP_BYPASS    = 6'd30;
    localparam t_op OP_STORE_A   = 6'd31;
    localparam t_op OP_STORE_B   = 6'd32;
    localparam t_op OP_RES_VAL   = 6'd33;
    localparam t_op OP_RES_ZERO  = 6'd34;

    typedef struct packed {
        t_op  op;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       vm_zero;
        logic       v_exact;
        logic       vidx_end;
        logic       vcur_gt;
        logic       hc_one;
        logic       top_zero;
        logic       hidx_end;
        logic       hcur_ge;
        logic [1:0] vmode;
        logic       bypass;
        logic       div_busy;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/ppi_ram.sv =====
`default_nettype none
module ppi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ppi_div.sv =====
`default_nettype none
module ppi_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ppi_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [ppi_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_busy,
    output logic      [ppi_pkg::DVD_W-1:0]  o_quotient,
    output logic      [ppi_pkg::DVS_W-1:0]  o_remainder
);
    import ppi_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DVD_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule
`default_nettype wire

// ===== rtl/ppi_datapath.sv =====
`default_nettype none
module ppi_datapath #(
    parameter int MAX_VERTICAL   = ppi_pkg::DEF_MAX_VERTICAL,
    parameter int MAX_HORIZONTAL = ppi_pkg::DEF_MAX_HORIZONTAL,
    parameter int CANDELA_DEPTH  = ppi_pkg::DEF_CANDELA_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_index,
    input  wire logic [ppi_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [ppi_pkg::IDX_W-1:0]  i_entry_index,
    input  wire logic [ppi_pkg::ANG_W-1:0]  i_angle_value,
    input  wire logic [ppi_pkg::CD_W-1:0]   i_candela_value,
    input  wire logic signed [ppi_pkg::QA_W-1:0] i_query_vertical,
    input  wire logic signed [ppi_pkg::QA_W-1:0] i_query_horizontal,
    input  wire ppi_pkg::t_cmd              i_cmd,
    output ppi_pkg::t_stat                  o_stat,
    output logic      [ppi_pkg::CD_W-1:0]   o_intensity,
    output logic                            o_index_error
);
    import ppi_pkg::*;

    localparam int VA_W = $clog2(MAX_VERTICAL);
    localparam int HA_W = (MAX_HORIZONTAL > 1) ? $clog2(MAX_HORIZONTAL) : 1;
    localparam int CA_W = $clog2(CANDELA_DEPTH);
    localparam logic [8:0]       MAXV  = 9'(MAX_VERTICAL);
    localparam logic [8:0]       MAXH  = 9'(MAX_HORIZONTAL);
    localparam logic [POS_W-1:0] CDEPTH = POS_W'(CANDELA_DEPTH);

    logic [CNT_W-1:0] r_vcount, r_hcount, w_vc, w_hc;
    logic [1:0]       r_type;
    logic [IDX_W-1:0] r_idx;
    logic [ANG_W-1:0] r_ang;
    logic [CD_W-1:0]  r_cd;
    logic signed [QA_W-1:0] r_qv, r_qh;
    logic [1:0]       r_vmode;
    logic [CNT_W-1:0] r_vidx, r_hidx, r_col;
    logic [ANG_W-1:0] r_vprev, r_vcur, r_top, r_hang, r_hprev, r_hcur;
    logic             r_ginv, r_bypass;
    logic [CD_W-1:0]  r_vp, r_vn, r_val, r_va, r_vb, r_res;
    logic             r_err;
    logic [ANG_W-1:0] r_num, r_den;
    logic [PRD_W-1:0] r_pa, r_pb;
    logic [CD_W-1:0]  r_oint;
    logic             r_oerr;

    logic [ANG_W-1:0] w_vq, w_hq;
    logic [CD_W-1:0]  w_gq, w_gval;
    logic [IDX_W-1:0] w_vra, w_hra;
    logic [CNT_W-1:0] w_gvi;
    logic [13:0]      w_cprod, w_area;
    logic [POS_W-1:0] w_pos, w_widx;
    logic             w_ginv, w_ld_ok;
    logic             w_vwe, w_hwe, w_cwe;
    logic [QA_W-1:0]  w_hmag;
    logic [15:0]      w_per, w_r1, w_r2;
    logic signed [15:0] w_num, w_den;
    logic [ANG_W-1:0] w_na, w_nb, w_da, w_db, w_dmn;
    logic             w_bset_h;
    logic [PRD_W-1:0] w_pa, w_pb;
    logic [DVD_W-1:0] w_acc, w_dvd, w_quo;
    logic [DVS_W-1:0] w_dvs, w_rem;
    logic             w_dstart, w_dbusy;
    logic [CD_W-1:0]  w_sat;

    // Counts in use: zero acts as one, above the table size acts as the size.
    always_comb begin
        if (r_vcount == '0) begin
            w_vc = CNT_W'(1);
        end else if ({2'b0, r_vcount} > MAXV) begin
            w_vc = MAXV[CNT_W-1:0];
        end else begin
            w_vc = r_vcount;
        end
        if (r_hcount == '0) begin
            w_hc = CNT_W'(1);
        end else if ({2'b0, r_hcount} > MAXH) begin
            w_hc = MAXH[CNT_W-1:0];
        end else begin
            w_hc = r_hcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= CNT_W'(1);
            r_hcount <= CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VCOUNT: r_vcount <= i_cfg_data;
                CFG_HCOUNT: r_hcount <= i_cfg_data;
                default:    r_vcount <= r_vcount;
            endcase
        end
    end

    // Table addresses
    always_comb begin
        case (i_cmd.op)
            OP_VLAST_RD: w_vra = {5'b0, w_vc - 1'b1};
            OP_V0_RD:    w_vra = '0;
            default:     w_vra = {5'b0, r_vidx};
        endcase
        case (i_cmd.op)
            OP_H_LAST_RD: w_hra = {5'b0, w_hc - 1'b1};
            OP_H0_RD:     w_hra = '0;
            default:      w_hra = {5'b0, r_hidx};
        endcase
        w_gvi   = (i_cmd.op == OP_GP_RD) ? r_vidx - 1'b1 : r_vidx;
        w_cprod = {7'b0, r_col} * {7'b0, w_vc};
        w_pos   = POS_W'(w_gvi) + POS_W'(w_cprod);
        w_ginv  = w_pos >= CDEPTH;
        w_widx  = POS_W'(r_idx);
        w_area  = {7'b0, w_vc} * {7'b0, w_hc};
        case (r_type)
            REQ_LDV: w_ld_ok = r_idx < IDX_W'(w_vc);
            REQ_LDH: w_ld_ok = r_idx < IDX_W'(w_hc);
            REQ_LDC: w_ld_ok = ({2'b0, r_idx} < w_area) && (w_widx < CDEPTH);
            default: w_ld_ok = 1'b0;
        endcase
        w_vwe = (i_cmd.op == OP_LOAD) && (r_type == REQ_LDV) && w_ld_ok;
        w_hwe = (i_cmd.op == OP_LOAD) && (r_type == REQ_LDH) && w_ld_ok;
        w_cwe = (i_cmd.op == OP_LOAD) && (r_type == REQ_LDC) && w_ld_ok;
    end

    ppi_ram #(.WIDTH(ANG_W), .DEPTH(MAX_VERTICAL)) u_vram (
        .i_clk   (i_clk),
        .i_we    (w_vwe),
        .i_waddr (r_idx[VA_W-1:0]),
        .i_wdata (r_ang),
        .i_raddr (w_vra[VA_W-1:0]),
        .o_rdata (w_vq)
    );

    ppi_ram #(.WIDTH(ANG_W), .DEPTH(MAX_HORIZONTAL)) u_hram (
        .i_clk   (i_clk),
        .i_we    (w_hwe),
        .i_waddr (r_idx[HA_W-1:0]),
        .i_wdata (r_ang),
        .i_raddr (w_hra[HA_W-1:0]),
        .o_rdata (w_hq)
    );

    ppi_ram #(.WIDTH(CD_W), .DEPTH(CANDELA_DEPTH)) u_cram (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_waddr (w_widx[CA_W-1:0]),
        .i_wdata (r_cd),
        .i_raddr (w_pos[CA_W-1:0]),
        .o_rdata (w_gq)
    );

    assign w_gval = r_ginv ? '0 : w_gq;

    // Horizontal wrap: non-negative remainder, then fold at the last angle.
    always_comb begin
        w_hmag = r_qh[QA_W-1] ? (~r_qh) + 1'b1 : r_qh;
        w_per  = {r_top, 1'b0};
        w_r1   = (r_qh[QA_W-1] && (w_rem != '0)) ? w_per - w_rem[15:0] : w_rem[15:0];
        w_r2   = (w_r1 > {1'b0, r_top}) ? w_per - w_r1 : w_r1;
    end

    // Blend operands
    always_comb begin
        w_bset_h = (i_cmd.op == OP_BSET_H);
        w_na  = w_bset_h ? r_hang  : r_qv[ANG_W-1:0];
        w_nb  = w_bset_h ? r_hprev : r_vprev;
        w_da  = w_bset_h ? r_hcur  : r_vcur;
        w_db  = w_nb;
        w_num = $signed({1'b0, w_na}) - $signed({1'b0, w_nb});
        w_den = $signed({1'b0, w_da}) - $signed({1'b0, w_db});
        w_dmn = r_den - r_num;
        w_pa  = {15'b0, r_vp} * {24'b0, w_dmn};
        w_pb  = {15'b0, r_vn} * {24'b0, r_num};
        w_acc = {1'b0, r_pa} + {1'b0, r_pb} + DVD_W'(r_den >> 1);
        w_sat = (w_quo[DVD_W-1:CD_W] != '0) ? '1 : w_quo[CD_W-1:0];
        w_dstart = ((i_cmd.op == OP_H_TOP) && (w_hq != '0)) || (i_cmd.op == OP_BADD);
        w_dvd = (i_cmd.op == OP_H_TOP) ? DVD_W'(w_hmag) : w_acc;
        w_dvs = (i_cmd.op == OP_H_TOP) ? {1'b0, w_hq, 1'b0} : DVS_W'(r_den);
    end

    ppi_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_dstart),
        .i_dividend  (w_dvd),
        .i_divisor   (w_dvs),
        .o_busy      (w_dbusy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_type <= i_req_type;
                r_idx  <= i_entry_index;
                r_ang  <= i_angle_value;
                r_cd   <= i_candela_value;
                r_qv   <= i_query_vertical;
                r_qh   <= i_query_horizontal;
            end
            OP_LOAD: begin
                r_res <= '0;
                r_err <= !w_ld_ok;
            end
            OP_VLAST_CHK: begin
                if (o_stat.vm_zero) begin
                    r_vmode <= VM_ZERO;
                end else if (o_stat.v_exact) begin
                    r_vmode <= VM_EXACT;
                    r_vidx  <= w_vc - 1'b1;
                end else begin
                    r_vmode <= VM_BLEND;
                end
            end
            OP_V0_LAT: begin
                r_vprev <= w_vq;
                r_vidx  <= CNT_W'(1);
            end
            OP_VS_STEP: begin
                if (o_stat.vcur_gt) begin
                    r_vcur <= w_vq;
                end else begin
                    r_vprev <= w_vq;
                    r_vidx  <= r_vidx + 1'b1;
                end
            end
            OP_VS_FAIL: r_vmode <= VM_ZERO;
            OP_H_TOP:   r_top   <= w_hq;
            OP_MOD_FIX: r_hang  <= w_r2[ANG_W-1:0];
            OP_H0_LAT: begin
                r_hprev <= w_hq;
                r_hidx  <= CNT_W'(1);
            end
            OP_HS_STEP: begin
                if (o_stat.hcur_ge) begin
                    r_hcur <= w_hq;
                end else begin
                    r_hprev <= w_hq;
                    r_hidx  <= r_hidx + 1'b1;
                end
            end
            OP_COL_A:   r_col <= (w_hc == CNT_W'(1)) ? '0 : r_hidx - 1'b1;
            OP_COL_B:   r_col <= r_hidx;
            OP_GP_RD:   r_ginv <= w_ginv;
            OP_GC_RD:   r_ginv <= w_ginv;
            OP_GP_LAT:  r_vp  <= w_gval;
            OP_GC_LAT:  r_vn  <= w_gval;
            OP_GC_VAL:  r_val <= w_gval;
            OP_VAL_ZERO: r_val <= '0;
            OP_BSET_V, OP_BSET_H: begin
                if (w_bset_h) begin
                    r_vp <= r_va;
                    r_vn <= r_vb;
                end
                r_bypass <= (w_num <= 16'sd0) || (w_den <= 16'sd0);
                r_num    <= (w_num > w_den) ? w_den[ANG_W-1:0] : w_num[ANG_W-1:0];
                r_den    <= w_den[ANG_W-1:0];
            end
            OP_BMUL: begin
                r_pa <= w_pa;
                r_pb <= w_pb;
            end
            OP_BDONE:   r_val <= w_sat;
            OP_BYPASS:  r_val <= r_vp;
            OP_STORE_A: r_va  <= r_val;
            OP_STORE_B: r_vb  <= r_val;
            OP_RES_VAL: begin
                r_res <= r_val;
                r_err <= 1'b0;
            end
            OP_RES_ZERO: begin
                r_res <= '0;
                r_err <= 1'b0;
            end
            default: r_res <= r_res;
        endcase
        if (i_cmd.push) begin
            r_oint <= r_res;
            r_oerr <= r_err;
        end
    end

    always_comb begin
        o_stat.req_type = r_type;
        o_stat.vm_zero  = r_qv[QA_W-1] || (r_qv[ANG_W-1:0] > w_vq);
        o_stat.v_exact  = !r_qv[QA_W-1] && (r_qv[ANG_W-1:0] == w_vq);
        o_stat.vidx_end = r_vidx >= w_vc;
        o_stat.vcur_gt  = w_vq > r_qv[ANG_W-1:0];
        o_stat.hc_one   = w_hc == CNT_W'(1);
        o_stat.top_zero = w_hq == '0;
        o_stat.hidx_end = r_hidx >= w_hc;
        o_stat.hcur_ge  = w_hq >= r_hang;
        o_stat.vmode    = r_vmode;
        o_stat.bypass   = r_bypass;
        o_stat.div_busy = w_dbusy;
    end

    assign o_intensity   = r_oint;
    assign o_index_error = r_oerr;
endmodule
`default_nettype wire

// ===== rtl/ppi_ctrl.sv =====
`default_nettype none
module ppi_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    input  wire ppi_pkg::t_stat i_stat,
    output ppi_pkg::t_cmd       o_cmd
);
    import ppi_pkg::*;

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_DISP  = 6'd1;
    localparam logic [5:0] S_LOAD  = 6'd2;
    localparam logic [5:0] S_VLA   = 6'd3;
    localparam logic [5:0] S_VLB   = 6'd4;
    localparam logic [5:0] S_V0A   = 6'd5;
    localparam logic [5:0] S_V0B   = 6'd6;
    localparam logic [5:0] S_VSA   = 6'd7;
    localparam logic [5:0] S_VSB   = 6'd8;
    localparam logic [5:0] S_HCHK  = 6'd9;
    localparam logic [5:0] S_HLA   = 6'd10;
    localparam logic [5:0] S_HLB   = 6'd11;
    localparam logic [5:0] S_MODW  = 6'd12;
    localparam logic [5:0] S_H0A   = 6'd13;
    localparam logic [5:0] S_H0B   = 6'd14;
    localparam logic [5:0] S_HSA   = 6'd15;
    localparam logic [5:0] S_HSB   = 6'd16;
    localparam logic [5:0] S_CSEL  = 6'd17;
    localparam logic [5:0] S_ZERO  = 6'd18;
    localparam logic [5:0] S_COL   = 6'd19;
    localparam logic [5:0] S_GXL   = 6'd20;
    localparam logic [5:0] S_GPL   = 6'd21;
    localparam logic [5:0] S_GCR   = 6'd22;
    localparam logic [5:0] S_GCL   = 6'd23;
    localparam logic [5:0] S_BSV   = 6'd24;
    localparam logic [5:0] S_BCHK  = 6'd25;
    localparam logic [5:0] S_BADD  = 6'd26;
    localparam logic [5:0] S_BWAIT = 6'd27;
    localparam logic [5:0] S_CEND  = 6'd28;
    localparam logic [5:0] S_CSELB = 6'd29;
    localparam logic [5:0] S_BSH   = 6'd30;
    localparam logic [5:0] S_RES   = 6'd31;
    localparam logic [5:0] S_DONE  = 6'd32;

    logic [5:0] r_state, n_state;
    logic       r_colb, n_colb;
    logic       r_hblend, n_hblend;
    logic       r_ovalid;
    logic [5:0] w_after;

    assign w_after = r_hblend ? S_RES : S_CEND;

    always_comb begin
        n_state    = r_state;
        n_colb     = r_colb;
        n_hblend   = r_hblend;
        o_cmd.op   = OP_NONE;
        o_cmd.push = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_hblend   = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DISP;
                end
            end
            S_DISP:  n_state = (i_stat.req_type == REQ_QUERY) ? S_VLA : S_LOAD;
            S_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = S_DONE;
            end
            S_VLA: begin
                o_cmd.op = OP_VLAST_RD;
                n_state  = S_VLB;
            end
            S_VLB: begin
                o_cmd.op = OP_VLAST_CHK;
                n_state  = (i_stat.vm_zero || i_stat.v_exact) ? S_HCHK : S_V0A;
            end
            S_V0A: begin
                o_cmd.op = OP_V0_RD;
                n_state  = S_V0B;
            end
            S_V0B: begin
                o_cmd.op = OP_V0_LAT;
                n_state  = S_VSA;
            end
            S_VSA: begin
                if (i_stat.vidx_end) begin
                    o_cmd.op = OP_VS_FAIL;
                    n_state  = S_HCHK;
                end else begin
                    o_cmd.op = OP_VS_RD;
                    n_state  = S_VSB;
                end
            end
            S_VSB: begin
                o_cmd.op = OP_VS_STEP;
                n_state  = i_stat.vcur_gt ? S_HCHK : S_VSA;
            end
            S_HCHK:  n_state = i_stat.hc_one ? S_CSEL : S_HLA;
            S_HLA: begin
                o_cmd.op = OP_H_LAST_RD;
                n_state  = S_HLB;
            end
            S_HLB: begin
                o_cmd.op = OP_H_TOP;
                n_state  = i_stat.top_zero ? S_ZERO : S_MODW;
            end
            S_MODW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_MOD_FIX;
                    n_state  = S_H0A;
                end
            end
            S_H0A: begin
                o_cmd.op = OP_H0_RD;
                n_state  = S_H0B;
            end
            S_H0B: begin
                o_cmd.op = OP_H0_LAT;
                n_state  = S_HSA;
            end
            S_HSA: begin
                if (i_stat.hidx_end) begin
                    n_state = S_ZERO;
                end else begin
                    o_cmd.op = OP_HS_RD;
                    n_state  = S_HSB;
                end
            end
            S_HSB: begin
                o_cmd.op = OP_HS_STEP;
                n_state  = i_stat.hcur_ge ? S_CSEL : S_HSA;
            end
            S_CSEL: begin
                o_cmd.op = OP_COL_A;
                n_colb   = 1'b0;
                n_state  = S_COL;
            end
            S_ZERO: begin
                o_cmd.op = OP_RES_ZERO;
                n_state  = S_DONE;
            end
            S_COL: begin
                case (i_stat.vmode)
                    VM_EXACT: begin
                        o_cmd.op = OP_GC_RD;
                        n_state  = S_GXL;
                    end
                    VM_BLEND: begin
                        o_cmd.op = OP_GP_RD;
                        n_state  = S_GPL;
                    end
                    default: begin
                        o_cmd.op = OP_VAL_ZERO;
                        n_state  = S_CEND;
                    end
                endcase
            end
            S_GXL: begin
                o_cmd.op = OP_GC_VAL;
                n_state  = S_CEND;
            end
            S_GPL: begin
                o_cmd.op = OP_GP_LAT;
                n_state  = S_GCR;
            end
            S_GCR: begin
                o_cmd.op = OP_GC_RD;
                n_state  = S_GCL;
            end
            S_GCL: begin
                o_cmd.op = OP_GC_LAT;
                n_state  = S_BSV;
            end
            S_BSV: begin
                o_cmd.op = OP_BSET_V;
                n_state  = S_BCHK;
            end
            S_BCHK: begin
                if (i_stat.bypass) begin
                    o_cmd.op = OP_BYPASS;
                    n_state  = w_after;
                end else begin
                    o_cmd.op = OP_BMUL;
                    n_state  = S_BADD;
                end
            end
            S_BADD: begin
                o_cmd.op = OP_BADD;
                n_state  = S_BWAIT;
            end
            S_BWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_BDONE;
                    n_state  = w_after;
                end
            end
            S_CEND: begin
                if (i_stat.hc_one) begin
                    n_state = S_RES;
                end else if (!r_colb) begin
                    o_cmd.op = OP_STORE_A;
                    n_colb   = 1'b1;
                    n_state  = S_CSELB;
                end else begin
                    o_cmd.op = OP_STORE_B;
                    n_state  = S_BSH;
                end
            end
            S_CSELB: begin
                o_cmd.op = OP_COL_B;
                n_state  = S_COL;
            end
            S_BSH: begin
                o_cmd.op = OP_BSET_H;
                n_hblend = 1'b1;
                n_state  = S_BCHK;
            end
            S_RES: begin
                o_cmd.op = OP_RES_VAL;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_colb   <= 1'b0;
            r_hblend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_colb   <= n_colb;
            r_hblend <= n_hblend;
            if (o_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
endmodule
`default_nettype wire

// ===== rtl/photometric_profile_interpolator.sv =====
`default_nettype none
// Photometric profile interpolator.
// The block holds a photometric table (vertical angles, horizontal angles and
// a candela grid) and answers bilinear intensity queries against it.
// Input words arrive on the s_axis channel: tuser carries the request kind
// (load vertical angle, load horizontal angle, load candela, query) and tdata
// carries the index, the angle, the candela value and the two query angles.
// Every input word produces exactly one output word on m_axis: the saturated
// Q16.8 intensity and an index error flag for loads outside the table in use.
// The two count registers are to be written over the cfg channel while idle;
// the block itself does not enforce this. A query scans the vertical and
// horizontal angle tables and passes through the shared bit-serial divider
// up to four times: once for the horizontal wrap and once per interpolation.
// The divider produces one quotient bit per cycle over 40 bits. One word is
// processed at a time.
// The output sits in a register: the next input word is accepted while the
// previous result still waits for m_axis_tready. When the receiver stalls,
// the engine finishes its current word and then holds until the output
// register frees up. Reset clears the control state and sets both counts to
// one; the tables keep whatever they held and must be loaded before use.
module photometric_profile_interpolator #(
    parameter int MAX_VERTICAL   = ppi_pkg::DEF_MAX_VERTICAL,
    parameter int MAX_HORIZONTAL = ppi_pkg::DEF_MAX_HORIZONTAL,
    parameter int CANDELA_DEPTH  = ppi_pkg::DEF_CANDELA_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: entry_index[11:0], angle_value[26:12],
    // candela_value[50:27], query_vertical[66:51], query_horizontal[82:67],
    // zero padding [87:83]
    input  wire logic [87:0] s_axis_tdata,
    // tuser: req_type[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: intensity[23:0], index_error[24], zero padding [31:25]
    output logic [31:0]      m_axis_tdata
);
    import ppi_pkg::*;

    t_cmd            w_cmd;
    t_stat           w_stat;
    logic [CD_W-1:0] w_intensity;
    logic            w_index_error;
    logic            w_in_accept;

    // Count registers are always writable.
    assign o_cfg_ready = 1'b1;
    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    ppi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ppi_datapath #(
        .MAX_VERTICAL   (MAX_VERTICAL),
        .MAX_HORIZONTAL (MAX_HORIZONTAL),
        .CANDELA_DEPTH  (CANDELA_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (s_axis_tuser),
        .i_entry_index      (s_axis_tdata[11:0]),
        .i_angle_value      (s_axis_tdata[26:12]),
        .i_candela_value    (s_axis_tdata[50:27]),
        .i_query_vertical   (s_axis_tdata[66:51]),
        .i_query_horizontal (s_axis_tdata[82:67]),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .o_intensity        (w_intensity),
        .o_index_error      (w_index_error)
    );

    assign m_axis_tdata = {7'b0, w_index_error, w_intensity};

    // The engine takes one word at a time, so it never accepts on two
    // consecutive edges.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> !s_axis_tready)
        else $error("input accepted while a word is in work");

    // A result is only pushed when the output register is free or draining.
    a_push_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result pushed over an untaken word");

    // An index error always comes with a zero intensity.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[24]) |-> (m_axis_tdata[23:0] == 24'd0))
        else $error("index error with nonzero intensity");

endmodule
`default_nettype wire

// ===== tb/sv/tb_photometric_profile_interpolator.sv =====
`default_nettype none
module tb_photometric_profile_interpolator;
    import ppi_pkg::*;

    localparam int NV = DEF_MAX_VERTICAL;
    localparam int NH = DEF_MAX_HORIZONTAL;
    localparam int ND = DEF_CANDELA_DEPTH;
    localparam int ANG_TOP = 23040;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int NUM_PHASES = 11;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    photometric_profile_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One expected output word: intensity and the index error flag.
    typedef struct packed {
        logic [23:0] intensity;
        logic        index_error;
    } t_result;

    // One row of the directed stimulus table. Rows with has_exp set carry an
    // expectation that is obvious from the table contents at that point.
    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] idx;
        logic [14:0] ang;
        logic [23:0] cd;
        logic [15:0] qv;
        logic [15:0] qh;
        logic        has_exp;
        logic [23:0] exp_int;
        logic        exp_err;
    } t_row;

    // Shadow copy of the photometric table and of the count registers.
    int unsigned vert_angles[NV];
    int unsigned horiz_angles[NH];
    int unsigned candela_grid[ND];
    int unsigned vcount_reg;
    int unsigned hcount_reg;

    t_result pending_results[$];
    int mismatches;
    int cycles;
    int send_idle_pct;
    int recv_stall_pct;

    function automatic int unsigned eff_count(int unsigned r, int unsigned mx);
        if (r == 0) return 1;
        if (r > mx) return mx;
        return r;
    endfunction

    function automatic int unsigned grid_value(int unsigned vi, int unsigned hi,
                                               int unsigned vc);
        int unsigned pos;
        pos = vi + hi * vc;
        if (pos >= ND) return 0;
        return candela_grid[pos];
    endfunction

    // Linear blend with half-up rounding; no extrapolation below the pair.
    function automatic int unsigned lerp_candela(int unsigned vp, int unsigned vn,
                                                 int num, int den);
        longint acc;
        if (num <= 0 || den <= 0) return vp;
        if (num > den) num = den;
        acc = longint'(vp) * (den - num) + longint'(vn) * num + den / 2;
        acc = acc / den;
        return (acc > 24'hFFFFFF) ? 24'hFFFFFF : int'(acc);
    endfunction

    function automatic int unsigned column_intensity(int unsigned hi, int v,
                                                     int unsigned vc);
        int last;
        int cur;
        int prv;
        last = int'(vert_angles[vc - 1]);
        if (v < 0 || v > last) return 0;
        if (v == last) return grid_value(vc - 1, hi, vc);
        for (int unsigned i = 1; i < vc; i++) begin
            cur = int'(vert_angles[i]);
            if (cur > v) begin
                prv = int'(vert_angles[i - 1]);
                return lerp_candela(grid_value(i - 1, hi, vc), grid_value(i, hi, vc),
                                    v - prv, cur - prv);
            end
        end
        return 0;
    endfunction

    function automatic int unsigned interpolate_intensity(int v, int h);
        int unsigned vc;
        int unsigned hc;
        int top;
        int period;
        int r;
        int cur;
        int prv;
        vc = eff_count(vcount_reg, NV);
        hc = eff_count(hcount_reg, NH);
        if (hc == 1) return column_intensity(0, v, vc);
        top = int'(horiz_angles[hc - 1]);
        if (top == 0) return 0;
        period = 2 * top;
        // The horizontal angle is folded into [0, top]: wrap, then mirror.
        r = h % period;
        if (r < 0) r += period;
        if (r > top) r = period - r;
        for (int unsigned i = 1; i < hc; i++) begin
            cur = int'(horiz_angles[i]);
            if (cur >= r) begin
                prv = int'(horiz_angles[i - 1]);
                return lerp_candela(column_intensity(i - 1, v, vc),
                                    column_intensity(i, v, vc), r - prv, cur - prv);
            end
        end
        return 0;
    endfunction

    // Updates the shadow table for loads and returns the word the block owes.
    function automatic t_result apply_request(logic [1:0] kind, int unsigned idx,
                                              int unsigned ang, int unsigned cd,
                                              logic [15:0] qv, logic [15:0] qh);
        t_result res;
        int unsigned vc;
        int unsigned hc;
        vc = eff_count(vcount_reg, NV);
        hc = eff_count(hcount_reg, NH);
        res = '0;
        case (kind)
            REQ_LDV: begin
                if (idx < vc) vert_angles[idx] = ang;
                else res.index_error = 1'b1;
            end
            REQ_LDH: begin
                if (idx < hc) horiz_angles[idx] = ang;
                else res.index_error = 1'b1;
            end
            REQ_LDC: begin
                if (idx < vc * hc && idx < ND) candela_grid[idx] = cd;
                else res.index_error = 1'b1;
            end
            default: begin
                res.intensity = 24'(interpolate_intensity(int'($signed(qv)),
                                                          int'($signed(qh))));
            end
        endcase
        return res;
    endfunction

    // Offers one word on the input stream and records its expected result once
    // the block takes it. A random pause before the word lowers tvalid first.
    task automatic send_word(logic [1:0] kind, int unsigned idx, int unsigned ang,
                             int unsigned cd, logic [15:0] qv, logic [15:0] qh,
                             logic has_exp, logic [23:0] exp_int, logic exp_err);
        t_result res;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, qh, qv, cd[23:0], ang[14:0], idx[11:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_request(kind, idx, ang, cd, qv, qh);
        if (has_exp) begin
            res.intensity   = exp_int;
            res.index_error = exp_err;
        end
        pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic idx, int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[6:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VCOUNT) vcount_reg = val;
        else hcount_reg = val;
        @(posedge i_clk);
    endtask

    // Fills every entry that the current counts use, so no query ever reads
    // a table entry that was never written. Most tables are ascending; some
    // are unordered, repeat angles, or have a zero horizontal period.
    task automatic load_tables();
        int unsigned vc;
        int unsigned hc;
        int unsigned style;
        int unsigned a;
        vc = eff_count(vcount_reg, NV);
        hc = eff_count(hcount_reg, NH);
        style = $urandom_range(7);
        a = $urandom_range(400);
        for (int unsigned i = 0; i < vc; i++) begin
            if (style == 1) a = $urandom_range(ANG_TOP);
            else if (i != 0) a = a + $urandom_range((style == 2) ? 0 : 1, 3000);
            if (a > ANG_TOP) a = ANG_TOP;
            send_word(REQ_LDV, i, a, 0, 16'h0, 16'h0, 1'b0, '0, 1'b0);
        end
        a = (style == 3) ? 0 : $urandom_range(1) * $urandom_range(300);
        for (int unsigned i = 0; i < hc; i++) begin
            if (style == 0) a = $urandom_range(ANG_TOP);
            else if (style != 3 && i != 0) a = a + $urandom_range(1, 4000);
            if (a > ANG_TOP) a = ANG_TOP;
            send_word(REQ_LDH, i, a, 0, 16'h0, 16'h0, 1'b0, '0, 1'b0);
        end
        for (int unsigned i = 0; i < vc * hc; i++)
            send_word(REQ_LDC, i, 0, $urandom_range(24'hFFFFFF), 16'h0, 16'h0,
                      1'b0, '0, 1'b0);
    endtask

    // Random word: mostly queries aimed at the table, some reloads inside the
    // table, some loads at any index (these often hit the index error).
    task automatic send_random_word();
        int unsigned vc;
        int unsigned hc;
        int unsigned pick;
        int top;
        int qv;
        int qh;
        vc = eff_count(vcount_reg, NV);
        hc = eff_count(hcount_reg, NH);
        pick = $urandom_range(99);
        if (pick < 6) begin
            send_word(REQ_LDC, $urandom_range(vc * hc - 1), $urandom_range(ANG_TOP),
                      $urandom_range(24'hFFFFFF), 16'h0, 16'h0, 1'b0, '0, 1'b0);
        end else if (pick < 9) begin
            send_word(($urandom_range(1) != 0) ? REQ_LDV : REQ_LDH, $urandom_range(vc - 1),
                      $urandom_range(ANG_TOP), 0, 16'h0, 16'h0, 1'b0, '0, 1'b0);
        end else if (pick < 16) begin
            send_word(2'($urandom_range(2)), $urandom_range(4095),
                      $urandom_range(32767), $urandom_range(24'hFFFFFF),
                      16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      1'b0, '0, 1'b0);
        end else begin
            top = int'(horiz_angles[hc - 1]);
            pick = $urandom_range(9);
            if (pick < 5) qv = $urandom_range(vert_angles[vc - 1] + 128) - 64;
            else if (pick < 7) qv = vert_angles[$urandom_range(vc - 1)];
            else qv = $urandom_range(65535) - 32768;
            pick = $urandom_range(9);
            if (pick < 5) qh = $urandom_range(4 * top + 200) - 2 * top - 100;
            else if (pick < 7) qh = horiz_angles[$urandom_range(hc - 1)];
            else qh = $urandom_range(65535) - 32768;
            if (qh > 32767) qh = 32767;
            if (qh < -32768) qh = -32768;
            send_word(REQ_QUERY, $urandom_range(4095), $urandom_range(32767),
                      $urandom_range(24'hFFFFFF), qv[15:0], qh[15:0], 1'b0, '0, 1'b0);
        end
    endtask

    // Output side: random stalls, and checking against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        m_axis_tready <= (recv_stall_pct == 0) ? 1'b1
                                               : ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[23:0] !== want.intensity ||
                    m_axis_tdata[24] !== want.index_error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: intensity exp %h got %h, error exp %b got %b",
                                 want.intensity, m_axis_tdata[23:0],
                                 want.index_error, m_axis_tdata[24]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Phase plan: count register values and idling mode. Zero and 127 test
    // the clamping of the counts.
    int phase_vc[NUM_PHASES]  = '{2, 4, 8, 0, 16, 6, 127, 2, 5, 1, 10};
    int phase_hc[NUM_PHASES]  = '{2, 3, 8, 5, 1, 0, 2, 127, 7, 9, 12};
    int phase_mode[NUM_PHASES] = '{0, 1, 2, 3, 0, 1, 0, 2, 3, 1, 2};
    int phase_items[NUM_PHASES] = '{60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 70};

    t_row directed[17];

    initial begin
        // Right after reset both counts are one, so every entry is a single
        // slot and the expected words can be written down directly.
        directed = '{
            '{REQ_LDV,   12'd0,    15'd100,   24'h0,      16'd0,     16'd0,     1'b1, 24'h0,      1'b0},
            '{REQ_LDH,   12'd0,    15'd0,     24'h0,      16'd0,     16'd0,     1'b1, 24'h0,      1'b0},
            '{REQ_LDC,   12'd0,    15'd0,     24'hFFFFFF, 16'd0,     16'd0,     1'b1, 24'h0,      1'b0},
            // Exactly at the last vertical angle returns the grid entry.
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'd100,   16'd0,     1'b1, 24'hFFFFFF, 1'b0},
            '{REQ_QUERY, 12'd4095, 15'h7FFF,  24'hFFFFFF, 16'hFFFF,  16'd0,     1'b1, 24'h0,      1'b0},
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'd101,   16'd5,     1'b1, 24'h0,      1'b0},
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'h8000,  16'h8000,  1'b1, 24'h0,      1'b0},
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'h7FFF,  16'h7FFF,  1'b1, 24'h0,      1'b0},
            // Below the last angle with a single entry: no enclosing pair.
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'd0,     16'd0,     1'b1, 24'h0,      1'b0},
            '{REQ_LDV,   12'd1,    15'd7,     24'h0,      16'd0,     16'd0,     1'b1, 24'h0,      1'b1},
            '{REQ_LDH,   12'd4095, 15'h7FFF,  24'h0,      16'd0,     16'd0,     1'b1, 24'h0,      1'b1},
            '{REQ_LDC,   12'd1,    15'd0,     24'h123456, 16'd0,     16'd0,     1'b1, 24'h0,      1'b1},
            '{REQ_LDC,   12'd4095, 15'd0,     24'hFFFFFF, 16'd0,     16'd0,     1'b1, 24'h0,      1'b1},
            '{REQ_LDV,   12'd0,    15'd23040, 24'h0,      16'd0,     16'd0,     1'b1, 24'h0,      1'b0},
            '{REQ_LDC,   12'd0,    15'd0,     24'hABCDEF, 16'd0,     16'd0,     1'b1, 24'h0,      1'b0},
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'd23040, 16'hFFFF,  1'b1, 24'hABCDEF, 1'b0},
            '{REQ_QUERY, 12'd0,    15'd0,     24'h0,      16'd23040, 16'd12345, 1'b1, 24'hABCDEF, 1'b0}
        };
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_VCOUNT;
        i_cfg_data     <= '0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= REQ_LDV;
        m_axis_tready  = 1'b1;
        cycles         = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        vcount_reg     = 1;
        hcount_reg     = 1;
        for (int i = 0; i < ND; i++) candela_grid[i] = 0;
        for (int i = 0; i < NV; i++) vert_angles[i] = 0;
        for (int i = 0; i < NH; i++) horiz_angles[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[r])
            send_word(directed[r].kind, directed[r].idx, directed[r].ang, directed[r].cd,
                      directed[r].qv, directed[r].qh, directed[r].has_exp,
                      directed[r].exp_int, directed[r].exp_err);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // The sender holds off here until the block has answered everything.
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            wait_drained();
            write_count(CFG_VCOUNT, phase_vc[p]);
            write_count(CFG_HCOUNT, phase_hc[p]);
            case (phase_mode[p])
                1: send_idle_pct = 68;
                2: recv_stall_pct = 68;
                3: begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
                default: ;
            endcase
            load_tables();
            repeat (phase_items[p]) send_random_word();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/ppi_pkg.sv
rtl/ppi_ram.sv
rtl/ppi_div.sv
rtl/ppi_datapath.sv
rtl/ppi_ctrl.sv
rtl/photometric_profile_interpolator.sv
tb/sv/tb_photometric_profile_interpolator.sv
